// ===== src/gpei_pkg.sv =====
package gpei_pkg;

    // Operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    // Register numbers
    localparam logic [3:0] REG_DIR     = 4'd0;
    localparam logic [3:0] REG_SET     = 4'd1;
    localparam logic [3:0] REG_CLR     = 4'd2;
    localparam logic [3:0] REG_PIN     = 4'd3;
    localparam logic [3:0] REG_EN_RISE = 4'd4;
    localparam logic [3:0] REG_EN_FALL = 4'd5;
    localparam logic [3:0] REG_ST_RISE = 4'd6;
    localparam logic [3:0] REG_ST_FALL = 4'd7;
    localparam logic [3:0] REG_INT_CLR = 4'd8;
    localparam logic [3:0] REG_SUMMARY = 4'd9;

    localparam int DATA_W = 32;

    localparam int DEF_PORT_COUNT     = 5;
    localparam int DEF_PINS_PER_PORT  = 32;
    localparam int DEF_IRQ_PORT_COUNT = 2;

    // Implemented interrupt pins per interrupt slot: port 0 lacks pins 12..14
    // and 31, port 2 has pins 0..13, further ports have every pin.
    function automatic logic [DATA_W-1:0] irq_pin_mask(input logic [1:0] slot);
        logic [DATA_W-1:0] m;
        begin
            case (slot)
                2'd0:    m = 32'h7FFF_8FFF;
                2'd1:    m = 32'h0000_3FFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== src/gpio_port_edge_interrupt_core.sv =====
// GPIO ports with edge interrupts, driven by a stream of requests.
//
// Input channel (in_valid / in_ready): one request per handshake, carrying
// operation (pin sample, register write, register read), port, reg_select
// and data. Output channel (out_valid / out_ready): exactly one result per
// request, carrying read_data, access_error and irq, in request order.
//
// A request accepted at an edge has its result on the outputs after that
// edge. Throughput is one request per cycle unless the receiver stalls; all
// the work is mask logic between the request ports and the result register,
// and port state updates in the same cycle so the next request sees it.
//
// When the receiver stalls, the result register holds and in_ready drops
// until the result is taken; the cycle it is taken a new request may enter.
//
// Reset (rst_n low, asynchronous) clears every direction, latch, sample,
// enable and status register and empties the result register. irq in a
// result reflects the status registers after that request has taken effect.
module gpio_port_edge_interrupt_core
    import gpei_pkg::*;
#(
    parameter int PORT_COUNT     = DEF_PORT_COUNT,
    parameter int PINS_PER_PORT  = DEF_PINS_PER_PORT,
    parameter int IRQ_PORT_COUNT = DEF_IRQ_PORT_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [2:0]        port,
    input  logic [3:0]        reg_select,
    input  logic [DATA_W-1:0] data,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_data,
    output logic              access_error,
    output logic              irq
);

    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int SW = (IRQ_PORT_COUNT > 1) ? $clog2(IRQ_PORT_COUNT) : 1;
    localparam logic [3:0] PORT_LIMIT = 4'(PORT_COUNT);
    localparam logic [2:0] IRQ_LIMIT  = 3'(IRQ_PORT_COUNT);

    typedef logic [PINS_PER_PORT-1:0] pins_t;

    // Per-port state
    pins_t dir_reg   [PORT_COUNT];
    pins_t latch_reg [PORT_COUNT];
    pins_t prev_reg  [PORT_COUNT];

    // Interrupt state, slot k belongs to port 2k
    pins_t en_rise_reg [IRQ_PORT_COUNT];
    pins_t en_fall_reg [IRQ_PORT_COUNT];
    pins_t st_rise_reg [IRQ_PORT_COUNT];
    pins_t st_fall_reg [IRQ_PORT_COUNT];
    pins_t st_rise_next [IRQ_PORT_COUNT];
    pins_t st_fall_next [IRQ_PORT_COUNT];

    // Result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              access_error_reg;
    logic              irq_reg;

    logic              in_fire;
    logic              port_ok;
    logic              is_irq;
    logic              err;
    logic              do_sample;
    logic              do_write;
    logic              do_read;
    logic [PW-1:0]     port_idx;
    logic [SW-1:0]     slot;
    pins_t             d;
    pins_t             dir_cur;
    pins_t             latch_cur;
    pins_t             prev_cur;
    pins_t             rd;
    pins_t             slot_mask;
    logic [DATA_W-1:0] summary_cur;
    logic [DATA_W-1:0] summary_wide;
    logic [DATA_W-1:0] read_data_next;
    logic              irq_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign port_idx = port[PW-1:0];
    assign slot     = port[SW:1];
    assign d        = data[PINS_PER_PORT-1:0];

    // Decode
    assign port_ok = ({1'b0, port} < PORT_LIMIT);
    assign is_irq  = port_ok && !port[0] && ({1'b0, port[2:1]} < IRQ_LIMIT);

    always_comb
    begin
        err = 1'b0;
        if (!port_ok || operation == OP_BAD)
        begin
            err = 1'b1;
        end
        else if (operation != OP_SAMPLE)
        begin
            if (reg_select > REG_SUMMARY)
            begin
                err = 1'b1;
            end
            else if (reg_select inside {[REG_EN_RISE:REG_INT_CLR]} && !is_irq)
            begin
                err = 1'b1;
            end
        end
    end

    assign do_sample = in_fire && !err && operation == OP_SAMPLE;
    assign do_write  = in_fire && !err && operation == OP_WRITE;
    assign do_read   = !err && operation == OP_READ;

    assign dir_cur   = port_ok ? dir_reg[port_idx]   : '0;
    assign latch_cur = port_ok ? latch_reg[port_idx] : '0;
    assign prev_cur  = port_ok ? prev_reg[port_idx]  : '0;

    // Only the implemented pins of this slot take enable writes
    always_comb
    begin
        logic [DATA_W-1:0] m;
        m = irq_pin_mask(2'(slot));
        slot_mask = m[PINS_PER_PORT-1:0];
    end

    // Status update: edges latch on a sample, int_clr clears
    always_comb
    begin
        for (int k = 0; k < IRQ_PORT_COUNT; k++)
        begin
            st_rise_next[k] = st_rise_reg[k];
            st_fall_next[k] = st_fall_reg[k];
            if (is_irq && slot == SW'(k))
            begin
                if (do_sample)
                begin
                    st_rise_next[k] = st_rise_reg[k] | (~prev_cur & d & en_rise_reg[k]);
                    st_fall_next[k] = st_fall_reg[k] | (prev_cur & ~d & en_fall_reg[k]);
                end
                else if (do_write && reg_select == REG_INT_CLR)
                begin
                    st_rise_next[k] = st_rise_reg[k] & ~d;
                    st_fall_next[k] = st_fall_reg[k] & ~d;
                end
            end
        end
    end

    // Pending ports: bit 2k for slot k
    always_comb
    begin
        summary_cur = '0;
        irq_next    = 1'b0;
        for (int k = 0; k < IRQ_PORT_COUNT; k++)
        begin
            summary_cur[2*k] = |(st_rise_reg[k] | st_fall_reg[k]);
            irq_next         = irq_next | (|(st_rise_next[k] | st_fall_next[k]));
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_select)
            REG_DIR:     rd = dir_cur;
            REG_SET:     rd = latch_cur;
            REG_PIN:     rd = (latch_cur & dir_cur) | (prev_cur & ~dir_cur);
            REG_EN_RISE: rd = en_rise_reg[slot];
            REG_EN_FALL: rd = en_fall_reg[slot];
            REG_ST_RISE: rd = st_rise_reg[slot];
            REG_ST_FALL: rd = st_fall_reg[slot];
            REG_SUMMARY: rd = summary_cur[PINS_PER_PORT-1:0];
            default:     rd = '0;
        endcase
        summary_wide = '0;
        summary_wide[PINS_PER_PORT-1:0] = rd;
        read_data_next = do_read ? summary_wide : '0;
    end

    // Port state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                dir_reg[i]   <= '0;
                latch_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            if (do_sample)
            begin
                prev_reg[port_idx] <= d;
            end
            if (do_write)
            begin
                case (reg_select)
                    REG_DIR: dir_reg[port_idx]   <= d;
                    REG_SET: latch_reg[port_idx] <= latch_cur | d;
                    REG_CLR: latch_reg[port_idx] <= latch_cur & ~d;
                    REG_PIN: latch_reg[port_idx] <= d;
                    default: ;
                endcase
            end
        end
    end

    // Interrupt state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < IRQ_PORT_COUNT; k++)
            begin
                en_rise_reg[k] <= '0;
                en_fall_reg[k] <= '0;
                st_rise_reg[k] <= '0;
                st_fall_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < IRQ_PORT_COUNT; k++)
            begin
                st_rise_reg[k] <= st_rise_next[k];
                st_fall_reg[k] <= st_fall_next[k];
            end
            if (do_write && is_irq)
            begin
                case (reg_select)
                    REG_EN_RISE: en_rise_reg[slot] <= d & slot_mask;
                    REG_EN_FALL: en_fall_reg[slot] <= d & slot_mask;
                    default: ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            read_data_reg    <= read_data_next;
            access_error_reg <= err;
            irq_reg          <= irq_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign access_error = access_error_reg;
    assign irq          = irq_reg;

`ifndef ASSERT_OFF
    // irq of a result matches the pending summary left behind by its request
    a_irq_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (irq == (summary_cur != '0)))
        else $error("irq disagrees with status registers");

    // a rejected request never returns data
    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && access_error) |-> (read_data == '0))
        else $error("read data on an access error");

    // samples on ports without interrupts leave the status alone
    a_plain_sample_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_SAMPLE && !is_irq) |=> $stable(summary_cur))
        else $error("status changed by sample on a plain port");

    // slot 0 enables stay within its implemented pins
    a_enable_within_pins: assert property (@(posedge clk) disable iff (!rst_n)
        ((en_rise_reg[0] | en_fall_reg[0]) & ~irq_pin_mask(2'd0)
            ) == '0)
        else $error("interrupt enable on an unimplemented pin");

    // a held result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request accepted while result stalled");
`endif

endmodule
